// ===== sv/efm_pkg.sv =====
// ----------------------------------------------------------------------------
// efm_pkg
// Shared types and constants of the extension field multiplier: channel
// field widths, request and register codes, datapath selects and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package efm_pkg;

  localparam int WORD_W  = 64;
  localparam int PROD_W  = 128;
  localparam int ACC_W   = 192;
  localparam int CIDX_W  = 4;
  localparam int RIDX_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W   = 8;
  localparam int RCNT_W  = 8;

  localparam logic REQ_POLY = 1'b0;
  localparam logic REQ_OPER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOINV = 1'b1;

  typedef enum logic [2:0] {
    X_OPA,
    X_POLY,
    X_HIGH,
    X_RAM,
    X_QUO
  } x_sel_e;

  typedef enum logic [1:0] {
    Y_OPB,
    Y_NEG,
    Y_RAM,
    Y_S1
  } y_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_CLR,
    ACC_ADD,
    ACC_LDM
  } acc_op_e;

  typedef enum logic [1:0] {
    RS_X,
    RS_PROD,
    RS_ACC,
    RS_R0
  } red_src_e;

  typedef struct packed {
    logic             in_we;
    logic             x_ld;
    x_sel_e           x_sel;
    logic             y_ld;
    y_sel_e           y_sel;
    logic             mul_go;
    acc_op_e          acc_op;
    logic             accm_we;
    logic             red_go;
    red_src_e         red_src;
    logic             red_by_r1;
    logic             eu_init;
    logic             nr_ld;
    logic             eu_step;
    logic             high_we;
    logic             tbl_we;
    logic             tbl_add;
    logic             add_ld;
    logic             out_ld;
    logic             out_zero;
    logic             out_last;
    logic             out_status;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic [IDX_W-1:0] ram_addr;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic red_busy;
    logic r1_zero;
    logic r0_one;
    logic out_busy;
  } stat_t;

endpackage

// ===== sv/efm_if.sv =====
// ----------------------------------------------------------------------------
// efm channel interfaces
// Valid/ready channels of the extension field multiplier: operand and
// polynomial words in, product words out, and the register write channel.
// ----------------------------------------------------------------------------
interface efm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [efm_pkg::CIDX_W-1:0]    coef_index;
  logic [efm_pkg::WORD_W-1:0]    coef_first;
  logic [efm_pkg::WORD_W-1:0]    coef_second;
  logic                          load_last;
  modport source (output valid, req_type, coef_index, coef_first, coef_second, load_last,
                  input ready);
  modport sink   (input valid, req_type, coef_index, coef_first, coef_second, load_last,
                  output ready);
endinterface

interface efm_out_if;
  logic                          valid;
  logic                          ready;
  logic [efm_pkg::WORD_W-1:0]    result_coef;
  logic [efm_pkg::RIDX_W-1:0]    result_index;
  logic                          result_last;
  logic                          status;
  modport source (output valid, result_coef, result_index, result_last, status,
                  input ready);
  modport sink   (input valid, result_coef, result_index, result_last, status,
                  output ready);
endinterface

interface efm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [efm_pkg::CFG_IDX_W-1:0] index;
  logic [efm_pkg::WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/extension_field_multiply_core.sv =====
// ----------------------------------------------------------------------------
// extension_field_multiply_core
// Multiplier in GF(p)[x]/(m(x)) with a loadable defining polynomial.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while the sequencer is idle. A polynomial
// load closed by load_last returns one status word: extended Euclid seeks
// the inverse of the leading coefficient, each step a bit-serial division
// plus a multiply and a bit-serial reduction; if it exists, the d*(d-1)
// entries of the reduction table are built. An operand load closed by
// load_last returns d product words; the run does the d*d schoolbook
// partial products and the d*(d-1) fold terms on the single 32x32
// multiplier, plus the 2*d-1 bit-serial 192-bit reductions. The finished
// word waits in an output register while new input words are taken.
// ----------------------------------------------------------------------------
module extension_field_multiply_core #(
  parameter int MAX_DEGREE = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  efm_in_if.sink     in_ch,
  efm_out_if.source  out_ch,
  efm_cfg_if.sink    cfg_ch
);

  logic [efm_pkg::WORD_W-1:0] prime_q, prime_eff;
  logic [efm_pkg::CIDX_W-1:0] degree_q, degree_eff;
  efm_pkg::cmd_t              cmd;
  efm_pkg::stat_t             stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q  <= efm_pkg::WORD_W'(2);
      degree_q <= efm_pkg::CIDX_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        efm_pkg::CFG_PRIME:  prime_q  <= cfg_ch.data;
        efm_pkg::CFG_DEGREE: degree_q <= cfg_ch.data[efm_pkg::CIDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign prime_eff  = (prime_q < efm_pkg::WORD_W'(2)) ? efm_pkg::WORD_W'(2) : prime_q;
  assign degree_eff = (degree_q == '0) ? efm_pkg::CIDX_W'(1) :
                      (int'(degree_q) > MAX_DEGREE) ? efm_pkg::CIDX_W'(MAX_DEGREE) :
                                                      degree_q;

  efm_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .degree_i       (degree_eff),
    .in_valid_i     (in_ch.valid),
    .in_req_type_i  (in_ch.req_type),
    .in_load_last_i (in_ch.load_last),
    .in_ready_o     (in_ch.ready),
    .cmd_o          (cmd),
    .stat_i         (stat)
  );

  efm_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .prime_i        (prime_eff),
    .req_type_i     (in_ch.req_type),
    .coef_index_i   (in_ch.coef_index),
    .coef_first_i   (in_ch.coef_first),
    .coef_second_i  (in_ch.coef_second),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .result_coef_o  (out_ch.result_coef),
    .result_index_o (out_ch.result_index),
    .result_last_o  (out_ch.result_last),
    .status_o       (out_ch.status)
  );

endmodule

// ===== sv/efm_ram.sv =====
// ----------------------------------------------------------------------------
// efm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module efm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/efm_datapath.sv =====
// ----------------------------------------------------------------------------
// efm_datapath
// Coefficient stores, 32x32 multiply sequencer, 192-bit accumulator,
// bit-serial remainder/quotient unit, Euclid registers, reduction table RAM
// and the output word register.
// ----------------------------------------------------------------------------
module efm_datapath #(
  parameter int MAX_DEGREE = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  efm_pkg::cmd_t                cmd_i,
  output efm_pkg::stat_t               stat_o,
  input  logic [efm_pkg::WORD_W-1:0]   prime_i,
  input  logic                         req_type_i,
  input  logic [efm_pkg::CIDX_W-1:0]   coef_index_i,
  input  logic [efm_pkg::WORD_W-1:0]   coef_first_i,
  input  logic [efm_pkg::WORD_W-1:0]   coef_second_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [efm_pkg::WORD_W-1:0]   result_coef_o,
  output logic [efm_pkg::RIDX_W-1:0]   result_index_o,
  output logic                         result_last_o,
  output logic                         status_o
);

  localparam int WW   = efm_pkg::WORD_W;
  localparam int PW   = efm_pkg::PROD_W;
  localparam int AW   = efm_pkg::ACC_W;
  localparam int PD   = MAX_DEGREE + 1;
  localparam int PIW  = $clog2(PD);
  localparam int OIW  = $clog2(MAX_DEGREE);
  localparam int HD   = MAX_DEGREE - 1;
  localparam int HIW  = (HD > 1) ? $clog2(HD) : 1;
  localparam int AD   = 2 * MAX_DEGREE - 1;
  localparam int AIW  = $clog2(AD);
  localparam int TD   = MAX_DEGREE * (MAX_DEGREE - 1);
  localparam int TAW  = $clog2(TD);

  logic [WW-1:0] poly_q [PD];
  logic [WW-1:0] opa_q  [MAX_DEGREE];
  logic [WW-1:0] opb_q  [MAX_DEGREE];
  logic [WW-1:0] high_q [HD];
  logic [AW-1:0] accm_q [AD];

  logic [WW-1:0] x_q, y_q;
  logic [PW-1:0] prod_q, prod_d, part_sh;
  logic [AW-1:0] acc_q;
  logic [1:0]    mcnt_q;
  logic          mbusy_q;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   part;

  logic [AW-1:0]            sh_q;
  logic [WW-1:0]            rem_q, quo_q, div_q;
  logic [efm_pkg::RCNT_W-1:0] rcnt_q;
  logic                     rbusy_q;
  logic [WW:0]              red_t, red_n;
  logic                     red_ge;

  logic [WW-1:0] r0_q, r1_q, s0_q, s1_q, nr_q, add_q;
  logic [WW:0]   add_sum;
  logic [WW-1:0] tbl_wdata, ram_rdata;

  logic                        out_valid_q;
  logic [WW-1:0]               out_coef_q;
  logic [efm_pkg::RIDX_W-1:0]  out_index_q;
  logic                        out_last_q;
  logic                        out_status_q;

  efm_ram #(
    .WIDTH (WW),
    .DEPTH (TD)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tbl_we),
    .waddr_i (cmd_i.ram_addr[TAW-1:0]),
    .wdata_i (tbl_wdata),
    .raddr_i (cmd_i.ram_addr[TAW-1:0]),
    .rdata_o (ram_rdata)
  );

  // multiply partial products, one 32x32 a cycle
  assign mul_a   = mcnt_q[1] ? x_q[63:32] : x_q[31:0];
  assign mul_b   = mcnt_q[0] ? y_q[63:32] : y_q[31:0];
  assign part    = mul_a * mul_b;
  assign part_sh = (mcnt_q == 2'd0) ? {64'd0, part} :
                   (mcnt_q == 2'd3) ? {part, 64'd0} : {32'd0, part, 32'd0};
  assign prod_d  = (mcnt_q == 2'd0) ? part_sh : prod_q + part_sh;

  // one long division step
  assign red_t  = {rem_q, sh_q[AW-1]};
  assign red_ge = red_t >= {1'b0, div_q};
  assign red_n  = red_ge ? red_t - {1'b0, div_q} : red_t;

  assign add_sum   = {1'b0, rem_q} + {1'b0, add_q};
  assign tbl_wdata = !cmd_i.tbl_add ? rem_q :
                     (add_sum >= {1'b0, prime_i}) ? WW'(add_sum - {1'b0, prime_i}) :
                                                    add_sum[WW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q     <= 1'b0;
      mcnt_q      <= 2'd0;
      rbusy_q     <= 1'b0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mul_go) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= 2'd0;
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q + 2'd1;
        if (mcnt_q == 2'd3) begin
          mbusy_q <= 1'b0;
        end
      end
      if (cmd_i.red_go) begin
        rbusy_q <= 1'b1;
        case (cmd_i.red_src)
          efm_pkg::RS_PROD: rcnt_q <= efm_pkg::RCNT_W'(PW);
          efm_pkg::RS_ACC:  rcnt_q <= efm_pkg::RCNT_W'(AW);
          default:          rcnt_q <= efm_pkg::RCNT_W'(WW);
        endcase
      end else if (rbusy_q) begin
        rcnt_q <= rcnt_q - efm_pkg::RCNT_W'(1);
        if (rcnt_q == efm_pkg::RCNT_W'(1)) begin
          rbusy_q <= 1'b0;
        end
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_we) begin
      if (req_type_i == efm_pkg::REQ_POLY) begin
        if (int'(coef_index_i) <= MAX_DEGREE) begin
          poly_q[PIW'(coef_index_i)] <= coef_first_i;
        end
      end else if (int'(coef_index_i) < MAX_DEGREE) begin
        opa_q[OIW'(coef_index_i)] <= coef_first_i;
        opb_q[OIW'(coef_index_i)] <= coef_second_i;
      end
    end

    if (cmd_i.x_ld) begin
      case (cmd_i.x_sel)
        efm_pkg::X_OPA:  x_q <= opa_q[cmd_i.a_idx[OIW-1:0]];
        efm_pkg::X_POLY: x_q <= poly_q[cmd_i.a_idx[PIW-1:0]];
        efm_pkg::X_HIGH: x_q <= high_q[cmd_i.a_idx[HIW-1:0]];
        efm_pkg::X_RAM:  x_q <= ram_rdata;
        efm_pkg::X_QUO:  x_q <= (quo_q >= prime_i) ? quo_q - prime_i : quo_q;
        default:         x_q <= x_q;
      endcase
    end
    if (cmd_i.y_ld) begin
      case (cmd_i.y_sel)
        efm_pkg::Y_OPB: y_q <= opb_q[cmd_i.b_idx[OIW-1:0]];
        efm_pkg::Y_NEG: y_q <= (s0_q == '0) ? '0 : prime_i - s0_q;
        efm_pkg::Y_RAM: y_q <= ram_rdata;
        efm_pkg::Y_S1:  y_q <= s1_q;
        default:        y_q <= y_q;
      endcase
    end

    if (mbusy_q) begin
      prod_q <= prod_d;
    end

    case (cmd_i.acc_op)
      efm_pkg::ACC_CLR: acc_q <= '0;
      efm_pkg::ACC_ADD: acc_q <= acc_q + {64'd0, prod_q};
      efm_pkg::ACC_LDM: acc_q <= accm_q[cmd_i.a_idx[AIW-1:0]];
      default:          acc_q <= acc_q;
    endcase
    if (cmd_i.accm_we) begin
      accm_q[cmd_i.a_idx[AIW-1:0]] <= acc_q;
    end

    if (cmd_i.red_go) begin
      rem_q <= '0;
      quo_q <= '0;
      div_q <= cmd_i.red_by_r1 ? r1_q : prime_i;
      case (cmd_i.red_src)
        efm_pkg::RS_PROD: sh_q <= {prod_q, 64'd0};
        efm_pkg::RS_ACC:  sh_q <= acc_q;
        efm_pkg::RS_R0:   sh_q <= {r0_q, 128'd0};
        default:          sh_q <= {x_q, 128'd0};
      endcase
    end else if (rbusy_q) begin
      rem_q <= red_n[WW-1:0];
      quo_q <= {quo_q[WW-2:0], red_ge};
      sh_q  <= {sh_q[AW-2:0], 1'b0};
    end

    if (cmd_i.eu_init) begin
      r0_q <= prime_i;
      r1_q <= rem_q;
      s0_q <= '0;
      s1_q <= WW'(1);
    end else if (cmd_i.eu_step) begin
      r0_q <= r1_q;
      r1_q <= nr_q;
      s0_q <= s1_q;
      s1_q <= (s0_q >= rem_q) ? s0_q - rem_q : s0_q + (prime_i - rem_q);
    end
    if (cmd_i.nr_ld) begin
      nr_q <= rem_q;
    end
    if (cmd_i.add_ld) begin
      add_q <= ram_rdata;
    end
    if (cmd_i.high_we) begin
      high_q[cmd_i.a_idx[HIW-1:0]] <= rem_q;
    end

    if (cmd_i.out_ld) begin
      out_coef_q   <= cmd_i.out_zero ? '0 : rem_q;
      out_index_q  <= cmd_i.a_idx[efm_pkg::RIDX_W-1:0];
      out_last_q   <= cmd_i.out_last;
      out_status_q <= cmd_i.out_status;
    end
  end

  assign stat_o.mul_busy = mbusy_q;
  assign stat_o.red_busy = rbusy_q;
  assign stat_o.r1_zero  = (r1_q == '0);
  assign stat_o.r0_one   = (r0_q == WW'(1));
  assign stat_o.out_busy = out_valid_q;

  assign out_valid_o    = out_valid_q;
  assign result_coef_o  = out_coef_q;
  assign result_index_o = out_index_q;
  assign result_last_o  = out_last_q;
  assign status_o       = out_status_q;

endmodule

// ===== sv/efm_ctrl.sv =====
// ----------------------------------------------------------------------------
// efm_ctrl
// Sequencer of the extension field multiplier: input word intake, modular
// inverse by Euclid, reduction table build, schoolbook product, high half
// reduction, fold back and result word emission.
// ----------------------------------------------------------------------------
module efm_ctrl #(
  parameter int MAX_DEGREE = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [efm_pkg::CIDX_W-1:0] degree_i,
  input  logic                       in_valid_i,
  input  logic                       in_req_type_i,
  input  logic                       in_load_last_i,
  output logic                       in_ready_o,
  output efm_pkg::cmd_t              cmd_o,
  input  efm_pkg::stat_t             stat_i
);

  localparam int CW = $clog2(2 * MAX_DEGREE);
  localparam int IW = efm_pkg::IDX_W;

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_INV_X   = 6'd1;
  localparam logic [5:0] S_INV_R   = 6'd2;
  localparam logic [5:0] S_INV_W   = 6'd3;
  localparam logic [5:0] S_EU      = 6'd4;
  localparam logic [5:0] S_DIV_W   = 6'd5;
  localparam logic [5:0] S_EMUL_W  = 6'd6;
  localparam logic [5:0] S_ERED_W  = 6'd7;
  localparam logic [5:0] S_INV_END = 6'd8;
  localparam logic [5:0] S_C0      = 6'd9;
  localparam logic [5:0] S_C0_MW   = 6'd10;
  localparam logic [5:0] S_C0_RW   = 6'd11;
  localparam logic [5:0] S_CJ      = 6'd12;
  localparam logic [5:0] S_CJ_T    = 6'd13;
  localparam logic [5:0] S_CI      = 6'd14;
  localparam logic [5:0] S_CI_X    = 6'd15;
  localparam logic [5:0] S_CI_A    = 6'd16;
  localparam logic [5:0] S_CI_MW   = 6'd17;
  localparam logic [5:0] S_CI_RW   = 6'd18;
  localparam logic [5:0] S_BOUT    = 6'd19;
  localparam logic [5:0] S_MK      = 6'd20;
  localparam logic [5:0] S_MI      = 6'd21;
  localparam logic [5:0] S_MMW     = 6'd22;
  localparam logic [5:0] S_MKS     = 6'd23;
  localparam logic [5:0] S_HJ      = 6'd24;
  localparam logic [5:0] S_HR      = 6'd25;
  localparam logic [5:0] S_HRW     = 6'd26;
  localparam logic [5:0] S_FI      = 6'd27;
  localparam logic [5:0] S_FJ      = 6'd28;
  localparam logic [5:0] S_FY      = 6'd29;
  localparam logic [5:0] S_FMW     = 6'd30;
  localparam logic [5:0] S_FR      = 6'd31;
  localparam logic [5:0] S_FRW     = 6'd32;

  logic [5:0]      state_q, state_d;
  logic [CW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic            status_q, status_d;
  logic [CW-1:0]   d, w, klast, kmi;
  logic [2*CW-1:0] a_iw, a_ij, a_top, a_prev;
  efm_pkg::cmd_t   cmd;

  assign d      = CW'(degree_i);
  assign w      = d - CW'(1);
  assign klast  = (d << 1) - CW'(2);
  assign kmi    = k_q - i_q;
  assign a_iw   = (2*CW)'(i_q) * (2*CW)'(w);
  assign a_ij   = a_iw + (2*CW)'(j_q);
  assign a_top  = (2*CW)'(w) * (2*CW)'(w) + (2*CW)'(j_q) - (2*CW)'(1);
  assign a_prev = a_iw - (2*CW)'(w) + (2*CW)'(j_q) - (2*CW)'(1);

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    status_d   = status_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.in_we = 1'b1;
          if (in_load_last_i) begin
            if (in_req_type_i == efm_pkg::REQ_POLY) begin
              state_d = S_INV_X;
            end else begin
              k_d     = '0;
              state_d = S_MK;
            end
          end
        end
      end
      // inverse of the leading coefficient
      S_INV_X: begin
        cmd.x_ld  = 1'b1;
        cmd.x_sel = efm_pkg::X_POLY;
        cmd.a_idx = IW'(d);
        state_d   = S_INV_R;
      end
      S_INV_R: begin
        cmd.red_go  = 1'b1;
        cmd.red_src = efm_pkg::RS_X;
        state_d     = S_INV_W;
      end
      S_INV_W: begin
        if (!stat_i.red_busy) begin
          cmd.eu_init = 1'b1;
          state_d     = S_EU;
        end
      end
      S_EU: begin
        if (stat_i.r1_zero) begin
          state_d = S_INV_END;
        end else begin
          cmd.red_go    = 1'b1;
          cmd.red_src   = efm_pkg::RS_R0;
          cmd.red_by_r1 = 1'b1;
          state_d       = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (!stat_i.red_busy) begin
          cmd.x_ld   = 1'b1;
          cmd.x_sel  = efm_pkg::X_QUO;
          cmd.y_ld   = 1'b1;
          cmd.y_sel  = efm_pkg::Y_S1;
          cmd.nr_ld  = 1'b1;
          cmd.mul_go = 1'b1;
          state_d    = S_EMUL_W;
        end
      end
      S_EMUL_W: begin
        if (!stat_i.mul_busy) begin
          cmd.red_go  = 1'b1;
          cmd.red_src = efm_pkg::RS_PROD;
          state_d     = S_ERED_W;
        end
      end
      S_ERED_W: begin
        if (!stat_i.red_busy) begin
          cmd.eu_step = 1'b1;
          state_d     = S_EU;
        end
      end
      S_INV_END: begin
        if (!stat_i.r0_one) begin
          status_d = efm_pkg::STATUS_NOINV;
          state_d  = S_BOUT;
        end else begin
          cmd.y_ld  = 1'b1;
          cmd.y_sel = efm_pkg::Y_NEG;
          i_d       = '0;
          state_d   = S_C0;
        end
      end
      // table column zero
      S_C0: begin
        cmd.x_ld   = 1'b1;
        cmd.x_sel  = efm_pkg::X_POLY;
        cmd.a_idx  = IW'(i_q);
        cmd.mul_go = 1'b1;
        state_d    = S_C0_MW;
      end
      S_C0_MW: begin
        if (!stat_i.mul_busy) begin
          cmd.red_go  = 1'b1;
          cmd.red_src = efm_pkg::RS_PROD;
          state_d     = S_C0_RW;
        end
      end
      S_C0_RW: begin
        if (!stat_i.red_busy) begin
          cmd.tbl_we   = 1'b1;
          cmd.ram_addr = IW'(a_iw);
          if (i_q == w) begin
            j_d     = CW'(1);
            state_d = S_CJ;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_C0;
          end
        end
      end
      // further table columns
      S_CJ: begin
        if (j_q >= w) begin
          status_d = efm_pkg::STATUS_OK;
          state_d  = S_BOUT;
        end else begin
          cmd.ram_addr = IW'(a_top);
          state_d      = S_CJ_T;
        end
      end
      S_CJ_T: begin
        cmd.y_ld  = 1'b1;
        cmd.y_sel = efm_pkg::Y_RAM;
        i_d       = '0;
        state_d   = S_CI;
      end
      S_CI: begin
        cmd.ram_addr = IW'(a_iw);
        state_d      = S_CI_X;
      end
      S_CI_X: begin
        cmd.x_ld     = 1'b1;
        cmd.x_sel    = efm_pkg::X_RAM;
        cmd.ram_addr = IW'(a_prev);
        state_d      = S_CI_A;
      end
      S_CI_A: begin
        cmd.add_ld = 1'b1;
        cmd.mul_go = 1'b1;
        state_d    = S_CI_MW;
      end
      S_CI_MW: begin
        if (!stat_i.mul_busy) begin
          cmd.red_go  = 1'b1;
          cmd.red_src = efm_pkg::RS_PROD;
          state_d     = S_CI_RW;
        end
      end
      S_CI_RW: begin
        if (!stat_i.red_busy) begin
          cmd.tbl_we   = 1'b1;
          cmd.tbl_add  = (i_q != '0);
          cmd.ram_addr = IW'(a_ij);
          if (i_q == w) begin
            j_d     = j_q + CW'(1);
            state_d = S_CJ;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_CI;
          end
        end
      end
      S_BOUT: begin
        if (!stat_i.out_busy) begin
          cmd.out_ld     = 1'b1;
          cmd.out_zero   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = status_q;
          state_d        = S_IDLE;
        end
      end
      // schoolbook product
      S_MK: begin
        cmd.acc_op = efm_pkg::ACC_CLR;
        i_d        = '0;
        state_d    = S_MI;
      end
      S_MI: begin
        if (i_q == d) begin
          state_d = S_MKS;
        end else if (k_q >= i_q && kmi < d) begin
          cmd.x_ld   = 1'b1;
          cmd.x_sel  = efm_pkg::X_OPA;
          cmd.a_idx  = IW'(i_q);
          cmd.y_ld   = 1'b1;
          cmd.y_sel  = efm_pkg::Y_OPB;
          cmd.b_idx  = IW'(kmi);
          cmd.mul_go = 1'b1;
          state_d    = S_MMW;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      S_MMW: begin
        if (!stat_i.mul_busy) begin
          cmd.acc_op = efm_pkg::ACC_ADD;
          i_d        = i_q + CW'(1);
          state_d    = S_MI;
        end
      end
      S_MKS: begin
        cmd.accm_we = 1'b1;
        cmd.a_idx   = IW'(k_q);
        if (k_q == klast) begin
          j_d     = '0;
          state_d = S_HJ;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = S_MK;
        end
      end
      // high half mod p
      S_HJ: begin
        if (j_q == w) begin
          i_d     = '0;
          state_d = S_FI;
        end else begin
          cmd.acc_op = efm_pkg::ACC_LDM;
          cmd.a_idx  = IW'(d + j_q);
          state_d    = S_HR;
        end
      end
      S_HR: begin
        cmd.red_go  = 1'b1;
        cmd.red_src = efm_pkg::RS_ACC;
        state_d     = S_HRW;
      end
      S_HRW: begin
        if (!stat_i.red_busy) begin
          cmd.high_we = 1'b1;
          cmd.a_idx   = IW'(j_q);
          j_d         = j_q + CW'(1);
          state_d     = S_HJ;
        end
      end
      // fold back through the table
      S_FI: begin
        cmd.acc_op = efm_pkg::ACC_LDM;
        cmd.a_idx  = IW'(i_q);
        j_d        = '0;
        state_d    = S_FJ;
      end
      S_FJ: begin
        if (j_q == w) begin
          state_d = S_FR;
        end else begin
          cmd.x_ld     = 1'b1;
          cmd.x_sel    = efm_pkg::X_HIGH;
          cmd.a_idx    = IW'(j_q);
          cmd.ram_addr = IW'(a_ij);
          state_d      = S_FY;
        end
      end
      S_FY: begin
        cmd.y_ld   = 1'b1;
        cmd.y_sel  = efm_pkg::Y_RAM;
        cmd.mul_go = 1'b1;
        state_d    = S_FMW;
      end
      S_FMW: begin
        if (!stat_i.mul_busy) begin
          cmd.acc_op = efm_pkg::ACC_ADD;
          j_d        = j_q + CW'(1);
          state_d    = S_FJ;
        end
      end
      S_FR: begin
        cmd.red_go  = 1'b1;
        cmd.red_src = efm_pkg::RS_ACC;
        state_d     = S_FRW;
      end
      S_FRW: begin
        if (!stat_i.red_busy && !stat_i.out_busy) begin
          cmd.out_ld     = 1'b1;
          cmd.a_idx      = IW'(i_q);
          cmd.out_last   = (i_q == w);
          cmd.out_status = efm_pkg::STATUS_OK;
          if (i_q == w) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_FI;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      status_q <= efm_pkg::STATUS_OK;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      status_q <= status_d;
    end
  end

  assign cmd_o = cmd;

endmodule
